### hdl/rvs_pkg.sv
// ----------------------------------------------------------------------------
// rvs_pkg
// Shared widths, memory geometry and operation codes for the RV32 subset
// instruction step block.
// ----------------------------------------------------------------------------
package rvs_pkg;

	localparam int XLEN           = 32;
	localparam int MODE_W         = 5;
	localparam int REG_IDX_W      = 5;
	localparam int NUM_REGS       = 32;
	localparam int MEM_ADDR_OUT_W = 12;

	localparam int MEM_BYTES = 4096;
	localparam int MEM_AW    = $clog2(MEM_BYTES);
	localparam int NUM_LANES = 4;
	localparam int ROWS      = MEM_BYTES / NUM_LANES;
	localparam int ROW_W     = MEM_AW - 2;

	localparam int LUI_SHIFT = 12;

	localparam logic [MODE_W-1:0] OP_ADD  = 5'd0;
	localparam logic [MODE_W-1:0] OP_SUB  = 5'd1;
	localparam logic [MODE_W-1:0] OP_AND  = 5'd2;
	localparam logic [MODE_W-1:0] OP_OR   = 5'd3;
	localparam logic [MODE_W-1:0] OP_XOR  = 5'd4;
	localparam logic [MODE_W-1:0] OP_SLT  = 5'd5;
	localparam logic [MODE_W-1:0] OP_SLL  = 5'd6;
	localparam logic [MODE_W-1:0] OP_SRA  = 5'd7;
	localparam logic [MODE_W-1:0] OP_ADDI = 5'd8;
	localparam logic [MODE_W-1:0] OP_ANDI = 5'd9;
	localparam logic [MODE_W-1:0] OP_ORI  = 5'd10;
	localparam logic [MODE_W-1:0] OP_XORI = 5'd11;
	localparam logic [MODE_W-1:0] OP_SLTI = 5'd12;
	localparam logic [MODE_W-1:0] OP_LW   = 5'd13;
	localparam logic [MODE_W-1:0] OP_LB   = 5'd14;
	localparam logic [MODE_W-1:0] OP_SW   = 5'd15;
	localparam logic [MODE_W-1:0] OP_SB   = 5'd16;
	localparam logic [MODE_W-1:0] OP_LUI  = 5'd17;

endpackage

### hdl/rvs_if.sv
// ----------------------------------------------------------------------------
// rvs_if
// Valid/ready channels: decoded instruction beats in, step result beats out.
// ----------------------------------------------------------------------------
interface rvs_item_if import rvs_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [MODE_W-1:0]           mode;
	logic [REG_IDX_W-1:0]        dest_or_data_reg;
	logic [REG_IDX_W-1:0]        src_reg_one;
	logic [REG_IDX_W-1:0]        src_reg_two;
	logic signed [XLEN-1:0]      immediate;

	modport source (output valid, mode, dest_or_data_reg, src_reg_one, src_reg_two,
		immediate, input ready);
	modport sink (input valid, mode, dest_or_data_reg, src_reg_one, src_reg_two,
		immediate, output ready);
endinterface

interface rvs_result_if import rvs_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic                        reg_written;
	logic [REG_IDX_W-1:0]        written_index;
	logic signed [XLEN-1:0]      written_value;
	logic                        mem_written;
	logic [MEM_ADDR_OUT_W-1:0]   mem_address;

	modport source (output valid, reg_written, written_index, written_value, mem_written,
		mem_address, input ready);
	modport sink (input valid, reg_written, written_index, written_value, mem_written,
		mem_address, output ready);
endinterface

### hdl/rv32_subset_instruction_step_top.sv
// ----------------------------------------------------------------------------
// rv32_subset_instruction_step_top
// Executes one decoded RV32 subset instruction per beat against a 32-entry
// register file and a byte-addressed data memory.
// ----------------------------------------------------------------------------
// Takes one instruction per cycle while result beats are taken and the
// memory clear is done; operands are registered into stage 1 as the beat
// is accepted, then execute/memory access into stage 2, then load assembly
// into the result register. Back-to-back dependencies are covered by
// forwarding from the writeback stage and write-through on the register
// file read. The whole pipe holds while a result waits to be taken. After
// reset the data memory is zeroed one row of four bytes per cycle until
// every row is cleared, during which item.ready stays low. The memory is four
// byte lanes, so an unaligned or wrapping word access hits each lane once.
module rv32_subset_instruction_step_top import rvs_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	rvs_item_if.sink       item,
	rvs_result_if.source   result
);

	logic                  en;
	logic                  accept;

	logic                  clr_busy_q;
	logic [ROW_W-1:0]      clr_row_q;

	logic [XLEN-1:0]       rf_q [NUM_REGS];
	logic [NUM_REGS-1:0]   rf_vld_q;
	logic                  rf_we;
	logic [REG_IDX_W-1:0]  rb_idx;
	logic [XLEN-1:0]       rd_a;
	logic [XLEN-1:0]       rd_b;

	logic                  vld_s1;
	logic [MODE_W-1:0]     mode_s1;
	logic [REG_IDX_W-1:0]  rd_s1;
	logic [REG_IDX_W-1:0]  rs1_s1;
	logic [REG_IDX_W-1:0]  rb_s1;
	logic [XLEN-1:0]       imm_s1;
	logic [XLEN-1:0]       opa_s1;
	logic [XLEN-1:0]       opb_s1;

	logic [XLEN-1:0]       opa;
	logic [XLEN-1:0]       opb;
	logic [XLEN-1:0]       sum_ai;
	logic [XLEN-1:0]       alu;
	logic                  wr_op;
	logic                  mem_op;
	logic                  ld_w;
	logic                  ld_b;
	logic                  st;
	logic                  st_w;
	logic                  store_go;
	logic [MEM_AW-1:0]     mem_addr;

	logic                  vld_s2;
	logic                  wr_s2;
	logic [REG_IDX_W-1:0]  rd_s2;
	logic [XLEN-1:0]       alu_s2;
	logic [MEM_AW-1:0]     addr_s2;
	logic                  ld_w_s2;
	logic                  ld_b_s2;
	logic                  mem_op_s2;
	logic                  st_s2;
	logic [7:0]            bank_rd_s2 [NUM_LANES];
	logic [XLEN-1:0]       ld_word;
	logic [XLEN-1:0]       res2;

	logic                       out_vld_q;
	logic                       out_reg_written_q;
	logic [REG_IDX_W-1:0]       out_index_q;
	logic [XLEN-1:0]            out_value_q;
	logic                       out_mem_written_q;
	logic [MEM_ADDR_OUT_W-1:0]  out_addr_q;

	assign en          = !out_vld_q || result.ready;
	assign item.ready  = en && !clr_busy_q;
	assign accept      = item.valid && item.ready;

	// memory clear after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			clr_row_q <= clr_row_q + ROW_W'(1);
			if (clr_row_q == ROW_W'(ROWS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// register file: two read ports with write-through
	assign rf_we  = en && vld_s2 && wr_s2;
	assign rb_idx = (item.mode inside {OP_SW, OP_SB}) ? item.dest_or_data_reg
		: item.src_reg_two;

	always_comb begin
		rd_a = rf_vld_q[item.src_reg_one] ? rf_q[item.src_reg_one] : '0;
		rd_b = rf_vld_q[rb_idx] ? rf_q[rb_idx] : '0;
		if (rf_we && rd_s2 == item.src_reg_one) begin
			rd_a = res2;
		end
		if (rf_we && rd_s2 == rb_idx) begin
			rd_b = res2;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_q[rd_s2] <= res2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (rf_we) begin
			rf_vld_q[rd_s2] <= 1'b1;
		end
	end

	// stage 1: operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en && accept) begin
			mode_s1 <= item.mode;
			rd_s1   <= item.dest_or_data_reg;
			rs1_s1  <= item.src_reg_one;
			rb_s1   <= rb_idx;
			imm_s1  <= item.immediate;
			opa_s1  <= rd_a;
			opb_s1  <= rd_b;
		end
	end

	always_comb begin
		opa    = (vld_s2 && wr_s2 && rd_s2 == rs1_s1) ? res2 : opa_s1;
		opb    = (vld_s2 && wr_s2 && rd_s2 == rb_s1) ? res2 : opb_s1;
		sum_ai = opa + imm_s1;
		alu    = '0;
		wr_op  = 1'b0;
		mem_op = 1'b0;
		ld_w   = 1'b0;
		ld_b   = 1'b0;
		st     = 1'b0;
		case (mode_s1)
			OP_ADD: begin
				alu   = opa + opb;
				wr_op = 1'b1;
			end
			OP_SUB: begin
				alu   = opa - opb;
				wr_op = 1'b1;
			end
			OP_AND: begin
				alu   = opa & opb;
				wr_op = 1'b1;
			end
			OP_OR: begin
				alu   = opa | opb;
				wr_op = 1'b1;
			end
			OP_XOR: begin
				alu   = opa ^ opb;
				wr_op = 1'b1;
			end
			OP_SLT: begin
				alu   = XLEN'($signed(opa) < $signed(opb));
				wr_op = 1'b1;
			end
			OP_SLL: begin
				alu   = opa << opb[4:0];
				wr_op = 1'b1;
			end
			OP_SRA: begin
				alu   = $unsigned($signed(opa) >>> opb[4:0]);
				wr_op = 1'b1;
			end
			OP_ADDI: begin
				alu   = sum_ai;
				wr_op = 1'b1;
			end
			OP_ANDI: begin
				alu   = opa & imm_s1;
				wr_op = 1'b1;
			end
			OP_ORI: begin
				alu   = opa | imm_s1;
				wr_op = 1'b1;
			end
			OP_XORI: begin
				alu   = opa ^ imm_s1;
				wr_op = 1'b1;
			end
			OP_SLTI: begin
				alu   = XLEN'($signed(opa) < $signed(imm_s1));
				wr_op = 1'b1;
			end
			OP_LW: begin
				mem_op = 1'b1;
				ld_w   = 1'b1;
				wr_op  = 1'b1;
			end
			OP_LB: begin
				mem_op = 1'b1;
				ld_b   = 1'b1;
				wr_op  = 1'b1;
			end
			OP_SW, OP_SB: begin
				mem_op = 1'b1;
				st     = 1'b1;
			end
			OP_LUI: begin
				alu   = imm_s1 << LUI_SHIFT;
				wr_op = 1'b1;
			end
			default: begin
				alu = '0;
			end
		endcase
	end

	assign mem_addr = sum_ai[MEM_AW-1:0];
	assign st_w     = (mode_s1 == OP_SW);
	assign store_go = en && vld_s1 && st;

	// data memory: four byte lanes, lane k holds addresses with addr % 4 == k
	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		logic [1:0]       lane_sel;
		logic [ROW_W-1:0] row;
		logic             we;
		logic [ROW_W-1:0] waddr;
		logic [7:0]       wdata;
		logic [7:0]       bank_q [ROWS];

		assign lane_sel = 2'(2'(k) - mem_addr[1:0]);
		assign row      = mem_addr[MEM_AW-1:2] + ROW_W'(2'(k) < mem_addr[1:0]);
		assign we       = clr_busy_q || (store_go && (st_w || lane_sel == 2'd0));
		assign waddr    = clr_busy_q ? clr_row_q : row;
		assign wdata    = clr_busy_q ? 8'h00 : opb[{lane_sel, 3'b000} +: 8];

		always_ff @(posedge clk) begin
			if (we) begin
				bank_q[waddr] <= wdata;
			end
			if (en) begin
				bank_rd_s2[k] <= bank_q[row];
			end
		end
	end

	// stage 2: load assembly and writeback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wr_s2     <= wr_op && (rd_s1 != '0);
			rd_s2     <= rd_s1;
			alu_s2    <= alu;
			addr_s2   <= mem_addr;
			ld_w_s2   <= ld_w;
			ld_b_s2   <= ld_b;
			mem_op_s2 <= mem_op;
			st_s2     <= st;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			ld_word[8*i +: 8] = bank_rd_s2[2'(addr_s2[1:0] + 2'(i))];
		end
		if (ld_w_s2) begin
			res2 = ld_word;
		end else if (ld_b_s2) begin
			res2 = {{(XLEN-8){ld_word[7]}}, ld_word[7:0]};
		end else begin
			res2 = alu_s2;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_reg_written_q <= wr_s2;
			out_index_q       <= wr_s2 ? rd_s2 : '0;
			out_value_q       <= wr_s2 ? res2 : '0;
			out_mem_written_q <= st_s2;
			out_addr_q        <= mem_op_s2 ? MEM_ADDR_OUT_W'(addr_s2) : '0;
		end
	end

	assign result.valid         = out_vld_q;
	assign result.reg_written   = out_reg_written_q;
	assign result.written_index = out_index_q;
	assign result.written_value = $signed(out_value_q);
	assign result.mem_written   = out_mem_written_q;
	assign result.mem_address   = out_addr_q;

endmodule

### dv/tb_rv32_subset_instruction_step_top.sv
// ----------------------------------------------------------------------------
// tb_rv32_subset_instruction_step_top
// Self-checking bench for the RV32 subset step block. Sends decoded
// instruction beats through a short directed table and then a weighted random
// stream. Loads and stores are mostly steered into small windows at both ends
// of memory, so that stored data is read back and wrapping word accesses
// occur. A shadow register file and byte memory predict the result beats,
// but fixed directed rows carry their own. Beats are compared field by field
// and in order, while both channels stall at random.
// ----------------------------------------------------------------------------
module tb_rv32_subset_instruction_step_top import rvs_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int RANDOM_ITEMS = 950;
	localparam int BLOCK_ITEMS  = 50;
	localparam int DRAIN_CYCLES = 10;
	localparam int N_DIRECTED   = 25;

	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 5'd18;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 5'd31;

	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [REG_IDX_W-1:0] rd;
		logic [REG_IDX_W-1:0] rs1;
		logic [REG_IDX_W-1:0] rs2;
		logic [XLEN-1:0]      imm;
	} instr_t;

	typedef struct packed {
		logic                      reg_written;
		logic [REG_IDX_W-1:0]      written_index;
		logic [XLEN-1:0]           written_value;
		logic                      mem_written;
		logic [MEM_ADDR_OUT_W-1:0] mem_address;
	} writeback_t;

	typedef struct {
		instr_t     ins;
		bit         fixed;
		writeback_t want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;

	rvs_item_if   instr_ch();
	rvs_result_if wb_ch();

	rv32_subset_instruction_step_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (instr_ch),
		.result (wb_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [XLEN-1:0] shadow_regs [NUM_REGS];
	logic [7:0]      shadow_mem  [MEM_BYTES];
	writeback_t      writebacks_due [$];
	int              mismatches = 0;
	int              cycle_count = 0;
	bit              calm = 1'b0;

	// x1..x19 are built up row by row; the fixed rows only use values known
	// at a glance (lui, x0 destination, unused modes, untouched memory).
	directed_row_t directed_rows [N_DIRECTED] = '{
		'{'{OP_LUI,  5'd1,  5'd0,  5'd0,  32'h0007_FFFF}, 1'b1,
			'{1'b1, 5'd1, 32'h7FFF_F000, 1'b0, 12'd0}},
		'{'{OP_LUI,  5'd2,  5'd0,  5'd0,  32'hFFF8_0000}, 1'b1,
			'{1'b1, 5'd2, 32'h8000_0000, 1'b0, 12'd0}},
		'{'{OP_LUI,  5'd0,  5'd0,  5'd0,  32'hFFFF_FFFF}, 1'b1, '0},
		'{'{OP_ADDI, 5'd3,  5'd0,  5'd0,  32'hFFFF_FFFF}, 1'b1,
			'{1'b1, 5'd3, 32'hFFFF_FFFF, 1'b0, 12'd0}},
		'{'{OP_ADDI, 5'd4,  5'd1,  5'd0,  32'h7FFF_FFFF}, 1'b0, '0},
		'{'{OP_ADD,  5'd5,  5'd2,  5'd2,  32'h0000_0000}, 1'b0, '0},
		'{'{OP_SUB,  5'd6,  5'd2,  5'd3,  32'h0000_0000}, 1'b0, '0},
		'{'{OP_AND,  5'd7,  5'd3,  5'd1,  32'h0000_0000}, 1'b0, '0},
		'{'{OP_OR,   5'd8,  5'd2,  5'd1,  32'h0000_0000}, 1'b0, '0},
		'{'{OP_XOR,  5'd9,  5'd8,  5'd3,  32'h0000_0000}, 1'b0, '0},
		'{'{OP_SLT,  5'd10, 5'd2,  5'd1,  32'h0000_0000}, 1'b0, '0},
		'{'{OP_SLTI, 5'd11, 5'd1,  5'd0,  32'h8000_0000}, 1'b0, '0},
		'{'{OP_ANDI, 5'd12, 5'd3,  5'd0,  32'h0000_0021}, 1'b0, '0},
		'{'{OP_ORI,  5'd13, 5'd0,  5'd0,  32'h8000_0000}, 1'b0, '0},
		'{'{OP_XORI, 5'd14, 5'd3,  5'd0,  32'h5555_5555}, 1'b0, '0},
		'{'{OP_SLL,  5'd15, 5'd3,  5'd12, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_SRA,  5'd16, 5'd2,  5'd12, 32'h0000_0000}, 1'b0, '0},
		'{'{OP_SW,   5'd1,  5'd3,  5'd0,  32'h0000_0000}, 1'b0, '0},
		'{'{OP_LW,   5'd17, 5'd0,  5'd0,  32'h0000_0FFF}, 1'b0, '0},
		'{'{OP_LB,   5'd18, 5'd0,  5'd0,  32'h0000_0000}, 1'b0, '0},
		'{'{OP_SB,   5'd3,  5'd0,  5'd0,  32'h8000_0000}, 1'b0, '0},
		'{'{OP_LW,   5'd0,  5'd0,  5'd0,  32'h0000_0FFF}, 1'b1,
			'{1'b0, 5'd0, 32'h0, 1'b0, 12'd4095}},
		'{'{OP_LW,   5'd19, 5'd0,  5'd0,  32'h0000_0800}, 1'b1,
			'{1'b1, 5'd19, 32'h0, 1'b0, 12'd2048}},
		'{'{MODE_UNUSED_LO, 5'd20, 5'd1, 5'd2, 32'hFFFF_FFFF}, 1'b1, '0},
		'{'{MODE_UNUSED_HI, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF}, 1'b1, '0}
	};

	function automatic writeback_t compute_writeback(instr_t ins);
		logic [XLEN-1:0] a, b, res, d;
		int unsigned     addr;
		logic            wr_reg;
		writeback_t      wb;
		a      = shadow_regs[ins.rs1];
		b      = shadow_regs[ins.rs2];
		res    = '0;
		wr_reg = 1'b0;
		wb     = '0;
		case (ins.mode)
			OP_ADD:  begin res = a + b; wr_reg = 1'b1; end
			OP_SUB:  begin res = a - b; wr_reg = 1'b1; end
			OP_AND:  begin res = a & b; wr_reg = 1'b1; end
			OP_OR:   begin res = a | b; wr_reg = 1'b1; end
			OP_XOR:  begin res = a ^ b; wr_reg = 1'b1; end
			OP_SLT:  begin res = {31'b0, ($signed(a) < $signed(b))}; wr_reg = 1'b1; end
			OP_SLL:  begin res = a << b[4:0]; wr_reg = 1'b1; end
			OP_SRA:  begin res = $signed(a) >>> b[4:0]; wr_reg = 1'b1; end
			OP_ADDI: begin res = a + ins.imm; wr_reg = 1'b1; end
			OP_ANDI: begin res = a & ins.imm; wr_reg = 1'b1; end
			OP_ORI:  begin res = a | ins.imm; wr_reg = 1'b1; end
			OP_XORI: begin res = a ^ ins.imm; wr_reg = 1'b1; end
			OP_SLTI: begin res = {31'b0, ($signed(a) < $signed(ins.imm))}; wr_reg = 1'b1; end
			OP_LW, OP_LB, OP_SW, OP_SB: begin
				addr = (a + ins.imm) % MEM_BYTES;
				wb.mem_address = addr[MEM_ADDR_OUT_W-1:0];
				if (ins.mode == OP_LW) begin
					res = {shadow_mem[(addr + 3) % MEM_BYTES], shadow_mem[(addr + 2) % MEM_BYTES],
						shadow_mem[(addr + 1) % MEM_BYTES], shadow_mem[addr]};
					wr_reg = 1'b1;
				end else if (ins.mode == OP_LB) begin
					res = {{24{shadow_mem[addr][7]}}, shadow_mem[addr]};
					wr_reg = 1'b1;
				end else begin
					d = shadow_regs[ins.rd];
					shadow_mem[addr] = d[7:0];
					if (ins.mode == OP_SW) begin
						shadow_mem[(addr + 1) % MEM_BYTES] = d[15:8];
						shadow_mem[(addr + 2) % MEM_BYTES] = d[23:16];
						shadow_mem[(addr + 3) % MEM_BYTES] = d[31:24];
					end
					wb.mem_written = 1'b1;
				end
			end
			OP_LUI:  begin res = ins.imm << LUI_SHIFT; wr_reg = 1'b1; end
			default: ;
		endcase
		if (wr_reg && ins.rd != '0) begin
			shadow_regs[ins.rd] = res;
			wb.reg_written      = 1'b1;
			wb.written_index    = ins.rd;
			wb.written_value    = res;
		end
		return wb;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// half the picks come from x1..x7 so that back-to-back dependencies are common
	function automatic logic [REG_IDX_W-1:0] pick_reg();
		return $urandom_range(0, 1) ? REG_IDX_W'($urandom_range(1, 7))
			: REG_IDX_W'($urandom_range(0, NUM_REGS - 1));
	endfunction

	function automatic logic [XLEN-1:0] pick_imm();
		logic [XLEN-1:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(0, 4095) - 32'd2048;
			1: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'h0000_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic instr_t random_instr();
		instr_t      ins;
		int unsigned pick, target;
		ins.rd  = pick_reg();
		ins.rs1 = pick_reg();
		ins.rs2 = pick_reg();
		ins.imm = pick_imm();
		pick    = $urandom_range(0, 99);
		if (pick < 4) begin
			ins.mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
		end else if (pick < 34) begin
			ins.mode = MODE_W'($urandom_range(OP_ADD, OP_SRA));
		end else if (pick < 54) begin
			ins.mode = MODE_W'($urandom_range(OP_ADDI, OP_SLTI));
		end else if (pick < 62) begin
			ins.mode = OP_LUI;
		end else begin
			if (pick < 79)
				ins.mode = $urandom_range(0, 1) ? OP_LW : OP_LB;
			else
				ins.mode = $urandom_range(0, 1) ? OP_SW : OP_SB;
			// steer most accesses into the low window or the wrapping top window
			if ($urandom_range(0, 3) != 0) begin
				target  = $urandom_range(0, 1) ? $urandom_range(0, 31)
					: $urandom_range(MEM_BYTES - 8, MEM_BYTES - 1);
				ins.imm = target - shadow_regs[ins.rs1];
			end
		end
		return ins;
	endfunction

	task automatic send_instr(instr_t ins, bit fixed, writeback_t want);
		writeback_t predicted;
		instr_ch.valid            <= 1'b1;
		instr_ch.mode             <= ins.mode;
		instr_ch.dest_or_data_reg <= ins.rd;
		instr_ch.src_reg_one      <= ins.rs1;
		instr_ch.src_reg_two      <= ins.rs2;
		instr_ch.immediate        <= ins.imm;
		do
			@(posedge clk);
		while (instr_ch.ready !== 1'b1);
		predicted = compute_writeback(ins);
		writebacks_due.push_back(fixed ? want : predicted);
	endtask

	task automatic hold_off(int unsigned cycles);
		if (cycles != 0) begin
			instr_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		instr_ch.valid <= 1'b0;
		while (writebacks_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic compare_field(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_writeback
		writeback_t got, want;
		if (arst_n === 1'b1 && wb_ch.valid === 1'b1 && wb_ch.ready === 1'b1) begin
			got = '{wb_ch.reg_written, wb_ch.written_index, wb_ch.written_value,
				wb_ch.mem_written, wb_ch.mem_address};
			if (writebacks_due.size() == 0) begin
				$display("%0t: result beat with none expected, expected none, actual %p",
					$time, got);
				mismatches++;
			end else begin
				want = writebacks_due.pop_front();
				compare_field("reg_written", XLEN'(want.reg_written), XLEN'(got.reg_written));
				compare_field("written_index", XLEN'(want.written_index),
					XLEN'(got.written_index));
				compare_field("written_value", want.written_value, got.written_value);
				compare_field("mem_written", XLEN'(want.mem_written), XLEN'(got.mem_written));
				compare_field("mem_address", XLEN'(want.mem_address), XLEN'(got.mem_address));
			end
		end
	end

	initial begin : sink_pacing
		int unsigned stall;
		wb_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = pick_gap();
			if (stall != 0) begin
				wb_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			wb_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		instr_t ins;
		int     counted, next_block;
		bit     drained_mid;
		counted     = 0;
		next_block  = 0;
		drained_mid = 1'b0;
		arst_n                    <= 1'b0;
		instr_ch.valid            <= 1'b0;
		instr_ch.mode             <= '0;
		instr_ch.dest_or_data_reg <= '0;
		instr_ch.src_reg_one      <= '0;
		instr_ch.src_reg_two      <= '0;
		instr_ch.immediate        <= '0;
		foreach (shadow_regs[i])
			shadow_regs[i] = '0;
		foreach (shadow_mem[i])
			shadow_mem[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			send_instr(directed_rows[i].ins, directed_rows[i].fixed, directed_rows[i].want);
			hold_off(pick_gap());
		end
		wait_drained();

		while (counted < RANDOM_ITEMS) begin
			if (counted >= next_block) begin
				calm       = ($urandom_range(0, 3) == 0);
				next_block = next_block + BLOCK_ITEMS;
			end
			ins = random_instr();
			send_instr(ins, 1'b0, '0);
			counted++;
			if (!drained_mid && counted >= RANDOM_ITEMS / 2) begin
				drained_mid = 1'b1;
				wait_drained();
			end else begin
				hold_off(pick_gap());
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

### filelist.f
hdl/rvs_pkg.sv
hdl/rvs_if.sv
hdl/rv32_subset_instruction_step_top.sv
dv/tb_rv32_subset_instruction_step_top.sv
